// File: rtl/vvpu_pkg.sv
package vvpu_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_FIRST = 2'd1,
        MODE_SECND = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_TIME_STEP = 3'd0,
        REG_BOX_X     = 3'd1,
        REG_BOX_Y     = 3'd2,
        REG_BOX_Z     = 3'd3,
        REG_INV_X     = 3'd4,
        REG_INV_Y     = 3'd5,
        REG_INV_Z     = 3'd6,
        REG_NONE      = 3'd7
    } reg_idx_t;

    localparam int W = 32;

    // one axis of a particle entry
    typedef struct packed {
        logic signed [W-1:0] pos;
        logic signed [W-1:0] vel;
        logic signed [W-1:0] svel;
        logic signed [W-1:0] sfrc;
        logic signed [W-1:0] disp;
    } axis_ent_t;

    function automatic logic signed [W-1:0] sat32(input logic signed [W+40-1:0] v);
        logic signed [W+40-1:0] hi;
        logic signed [W+40-1:0] lo;
        begin
            hi = (W+40)'(signed'(33'sh0_7FFF_FFFF));
            lo = -(W+40)'(signed'(33'sh0_8000_0000));
            if (v > hi)
                sat32 = 32'sh7FFF_FFFF;
            else if (v < lo)
                sat32 = 32'sh8000_0000;
            else
                sat32 = v[W-1:0];
        end
    endfunction

endpackage

// File: rtl/velocity_verlet_particle_update.sv
// Pipeline: memory read stage, six compute stages, output register; a stall on a
// valid output freezes the pipeline.
// Throughput: one particle per cycle while the output is not stalled; a transaction
// whose particle is still in flight waits until the older one has written back.
// Reset clears the pipeline and output valid bits and loads the config registers
// with their defaults; memory contents are undefined until a load writes the entry.
module velocity_verlet_particle_update #(
    parameter int NUM_PARTICLES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [9:0]         particle_index,
    input  logic signed [31:0] vec_a_x,
    input  logic signed [31:0] vec_a_y,
    input  logic signed [31:0] vec_a_z,
    input  logic signed [31:0] vec_b_x,
    input  logic signed [31:0] vec_b_y,
    input  logic signed [31:0] vec_b_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [9:0]         out_index,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic signed [31:0] disp_x,
    output logic signed [31:0] disp_y,
    output logic signed [31:0] disp_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import vvpu_pkg::*;

    localparam int AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
    localparam int DEPTH = 8;

    logic [15:0] dt_reg;
    logic [30:0] blx_reg, bly_reg, blz_reg;
    logic [31:0] ivx_reg, ivy_reg, ivz_reg;

    logic          adv;
    logic          in_ok;
    logic          hazard;
    logic          go;
    logic [AW-1:0] addr;
    logic [DEPTH-2:0] vld_reg;
    logic [DEPTH-2:0] inr_reg;
    logic [9:0]    idx_pipe_reg [0:DEPTH-2];
    axis_ent_t     rx, ry, rz;

    logic          ov_reg;
    logic [9:0]    oi_reg;
    axis_ent_t     ox_reg, oy_reg, oz_reg;
    logic          last_v, last_in;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg  <= 16'd655;
            blx_reg <= 31'd655360;
            bly_reg <= 31'd655360;
            blz_reg <= 31'd655360;
            ivx_reg <= 32'd429496730;
            ivy_reg <= 32'd429496730;
            ivz_reg <= 32'd429496730;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_TIME_STEP: dt_reg  <= cfg_data[15:0];
                REG_BOX_X:     blx_reg <= cfg_data[30:0];
                REG_BOX_Y:     bly_reg <= cfg_data[30:0];
                REG_BOX_Z:     blz_reg <= cfg_data[30:0];
                REG_INV_X:     ivx_reg <= cfg_data;
                REG_INV_Y:     ivy_reg <= cfg_data;
                REG_INV_Z:     ivz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // same particle still in the pipeline: hold the input until it has written back
    always_comb
    begin
        hazard = 1'b0;
        for (int i = 0; i < DEPTH-1; i++)
            if (vld_reg[i] && inr_reg[i] && idx_pipe_reg[i] == particle_index)
                hazard = 1'b1;
    end

    assign last_v  = vld_reg[DEPTH-2];
    assign last_in = inr_reg[DEPTH-2];
    // pipeline advances unless the output register is full and stalled
    assign adv      = !(ov_reg && out_stall);
    assign in_stall = !adv || hazard;
    assign in_ok    = 32'(particle_index) < NUM_PARTICLES;
    assign go       = in_valid && !hazard && in_ok;
    assign addr     = particle_index[AW-1:0];

    vvpu_axis #(.AW(AW)) u_x (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_go(go), .in_mode(mode),
        .in_addr(addr), .in_a(vec_a_x), .in_b(vec_b_x), .dt(dt_reg),
        .blen(blx_reg), .binv(ivx_reg), .res(rx)
    );
    vvpu_axis #(.AW(AW)) u_y (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_go(go), .in_mode(mode),
        .in_addr(addr), .in_a(vec_a_y), .in_b(vec_b_y), .dt(dt_reg),
        .blen(bly_reg), .binv(ivy_reg), .res(ry)
    );
    vvpu_axis #(.AW(AW)) u_z (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_go(go), .in_mode(mode),
        .in_addr(addr), .in_a(vec_a_z), .in_b(vec_b_z), .dt(dt_reg),
        .blen(blz_reg), .binv(ivz_reg), .res(rz)
    );

    // Mode three reads the entry and writes it back unchanged.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            inr_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-3:0], in_valid && !hazard};
            inr_reg <= {inr_reg[DEPTH-3:0], in_ok};
            ov_reg  <= last_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_pipe_reg[0] <= particle_index;
            for (int i = 1; i < DEPTH-1; i++)
                idx_pipe_reg[i] <= idx_pipe_reg[i-1];
            oi_reg <= idx_pipe_reg[DEPTH-2];
            ox_reg <= last_in ? rx : '0;
            oy_reg <= last_in ? ry : '0;
            oz_reg <= last_in ? rz : '0;
        end
    end

    assign out_valid = ov_reg;
    assign out_index = oi_reg;
    assign pos_x  = ox_reg.pos;
    assign pos_y  = oy_reg.pos;
    assign pos_z  = oz_reg.pos;
    assign vel_x  = ox_reg.vel;
    assign vel_y  = oy_reg.vel;
    assign vel_z  = oz_reg.vel;
    assign disp_x = ox_reg.disp;
    assign disp_y = oy_reg.disp;
    assign disp_z = oz_reg.disp;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(out_index))
        else $error("stalled transaction changed");

    a_pipe_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && last_v) |=> out_valid)
        else $error("item lost before output");

    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && last_v && !last_in) |=> (pos_x == '0 && vel_x == '0 && disp_x == '0))
        else $error("out of range result not zero");

endmodule

// File: rtl/vvpu_axis.sv
module vvpu_axis #(
    parameter int AW = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_go,
    input  logic [1:0]             in_mode,
    input  logic [AW-1:0]          in_addr,
    input  logic signed [31:0]     in_a,
    input  logic signed [31:0]     in_b,
    input  logic [15:0]            dt,
    input  logic [30:0]            blen,
    input  logic [31:0]            binv,
    output vvpu_pkg::axis_ent_t    res
);
    import vvpu_pkg::*;

    axis_ent_t mem [0:(1<<AW)-1];

    // stage 1: memory read, operands registered
    logic            s1_go_reg;
    logic [1:0]      s1_mode_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic signed [31:0] s1_a_reg, s1_b_reg;
    axis_ent_t       s1_rd_reg;

    // stage 2: products dt*f and dt*(f+sf)
    logic            s2_go_reg;
    logic [1:0]      s2_mode_reg;
    logic [AW-1:0]   s2_addr_reg;
    logic signed [31:0] s2_a_reg, s2_b_reg;
    axis_ent_t       s2_e_reg;
    logic signed [48:0] s2_p1_reg, s2_p2_reg;

    // stage 3: u and new velocity for mode 2
    logic            s3_go_reg;
    logic [1:0]      s3_mode_reg;
    logic [AW-1:0]   s3_addr_reg;
    logic signed [31:0] s3_a_reg, s3_b_reg;
    axis_ent_t       s3_e_reg;
    logic signed [33:0] s3_u_reg;
    logic signed [31:0] s3_v2_reg;

    // stage 4: d = (u*dt)>>16
    logic            s4_go_reg;
    logic [1:0]      s4_mode_reg;
    logic [AW-1:0]   s4_addr_reg;
    logic signed [31:0] s4_a_reg, s4_b_reg;
    axis_ent_t       s4_e_reg;
    logic signed [33:0] s4_u_reg;
    logic signed [31:0] s4_v2_reg;
    logic signed [34:0] s4_d_reg;

    // stage 5: q and new displacement
    logic            s5_go_reg;
    logic [1:0]      s5_mode_reg;
    logic [AW-1:0]   s5_addr_reg;
    logic signed [31:0] s5_a_reg, s5_b_reg;
    axis_ent_t       s5_e_reg;
    logic signed [31:0] s5_u_reg;
    logic signed [31:0] s5_v2_reg;
    logic signed [31:0] s5_q_reg;
    logic signed [31:0] s5_dsp_reg;

    // stage 6: k = (q*inv)>>48
    logic            s6_go_reg;
    logic [1:0]      s6_mode_reg;
    logic [AW-1:0]   s6_addr_reg;
    logic signed [31:0] s6_a_reg, s6_b_reg;
    axis_ent_t       s6_e_reg;
    logic signed [31:0] s6_u_reg, s6_v2_reg, s6_q_reg, s6_dsp_reg;
    logic signed [16:0] s6_k_reg;

    // stage 7: k*L, writeback
    logic            s7_go_reg;
    logic [AW-1:0]   s7_addr_reg;
    axis_ent_t       s7_new_reg;

    logic signed [48:0] kl;
    axis_ent_t       wb;
    logic [1:0]      s6_mode_c;

    // The top level holds back an item whose entry is still in flight, so
    // every read returns the committed entry.
    always_ff @(posedge clk)
    begin
        if (adv && in_go)
            s1_rd_reg <= mem[in_addr];
        if (s7_go_reg && adv)
            mem[s7_addr_reg] <= s7_new_reg;
    end

    // write result of s6 stage (its new entry)
    always_comb
    begin
        s6_mode_c = s6_mode_reg;
        wb = s6_e_reg;
        unique case (s6_mode_c)
            MODE_LOAD:
            begin
                wb.pos  = s6_a_reg;
                wb.vel  = s6_b_reg;
                wb.disp = '0;
            end
            MODE_FIRST:
            begin
                wb.sfrc = s6_a_reg;
                wb.svel = s6_e_reg.vel;
                wb.disp = s6_dsp_reg;
                wb.pos  = sat32(72'(s6_q_reg) - 72'(kl));
                wb.vel  = s6_u_reg;
            end
            MODE_SECND: wb.vel = s6_v2_reg;
            default: wb = s6_e_reg;
        endcase
    end

    assign kl = 49'(s6_k_reg) * 49'(signed'({1'b0, blen}));
    assign res = s7_new_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_go_reg <= 1'b0;
            s2_go_reg <= 1'b0;
            s3_go_reg <= 1'b0;
            s4_go_reg <= 1'b0;
            s5_go_reg <= 1'b0;
            s6_go_reg <= 1'b0;
            s7_go_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_go_reg <= in_go;
            s2_go_reg <= s1_go_reg;
            s3_go_reg <= s2_go_reg;
            s4_go_reg <= s3_go_reg;
            s5_go_reg <= s4_go_reg;
            s6_go_reg <= s5_go_reg;
            s7_go_reg <= s6_go_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mode_reg <= in_mode;
            s1_addr_reg <= in_addr;
            s1_a_reg    <= in_a;
            s1_b_reg    <= in_b;

            s2_mode_reg <= s1_mode_reg;
            s2_addr_reg <= s1_addr_reg;
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_e_reg    <= s1_rd_reg;
            s2_p1_reg   <= 49'(s1_a_reg) * 49'(signed'({1'b0, dt}));
            s2_p2_reg   <= 49'(50'(s1_a_reg) + 50'(s1_rd_reg.sfrc))
                           * 49'(signed'({1'b0, dt}));

            s3_mode_reg <= s2_mode_reg;
            s3_addr_reg <= s2_addr_reg;
            s3_a_reg    <= s2_a_reg;
            s3_b_reg    <= s2_b_reg;
            s3_e_reg    <= s2_e_reg;
            s3_u_reg    <= 34'(s2_e_reg.vel) + 34'(s2_p1_reg >>> 17);
            s3_v2_reg   <= sat32(72'(s2_e_reg.svel) + 72'(s2_p2_reg >>> 17));

            s4_mode_reg <= s3_mode_reg;
            s4_addr_reg <= s3_addr_reg;
            s4_a_reg    <= s3_a_reg;
            s4_b_reg    <= s3_b_reg;
            s4_e_reg    <= s3_e_reg;
            s4_u_reg    <= s3_u_reg;
            s4_v2_reg   <= s3_v2_reg;
            s4_d_reg    <= 35'((51'(s3_u_reg) * 51'(signed'({1'b0, dt}))) >>> 16);

            s5_mode_reg <= s4_mode_reg;
            s5_addr_reg <= s4_addr_reg;
            s5_a_reg    <= s4_a_reg;
            s5_b_reg    <= s4_b_reg;
            s5_e_reg    <= s4_e_reg;
            s5_u_reg    <= sat32(72'(s4_u_reg));
            s5_v2_reg   <= s4_v2_reg;
            s5_q_reg    <= sat32(72'(s4_e_reg.pos) + 72'(s4_d_reg));
            s5_dsp_reg  <= sat32(72'(s4_e_reg.disp) + 72'(s4_d_reg));

            s6_mode_reg <= s5_mode_reg;
            s6_addr_reg <= s5_addr_reg;
            s6_a_reg    <= s5_a_reg;
            s6_b_reg    <= s5_b_reg;
            s6_e_reg    <= s5_e_reg;
            s6_u_reg    <= s5_u_reg;
            s6_v2_reg   <= s5_v2_reg;
            s6_q_reg    <= s5_q_reg;
            s6_dsp_reg  <= s5_dsp_reg;
            s6_k_reg    <= 17'((65'(s5_q_reg) * 65'(signed'({1'b0, binv}))) >>> 48);

            s7_addr_reg <= s6_addr_reg;
            s7_new_reg  <= wb;
        end
    end

    a_wb_known: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s6_go_reg) |=> s7_go_reg)
        else $error("writeback stage lost an item");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv) |=> $stable(s7_addr_reg) && $stable(s7_go_reg))
        else $error("pipeline moved without advance");

    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s6_go_reg && s6_mode_reg == MODE_LOAD) |=> s7_new_reg.disp == '0)
        else $error("load did not clear displacement");

endmodule

// File: tb/sv/tb_velocity_verlet_particle_update.sv
module tb_velocity_verlet_particle_update;
    import vvpu_pkg::*;

    typedef struct {
        logic [1:0]         mode;
        logic [9:0]         idx;
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
    } step_t;

    typedef struct {
        logic [9:0]         idx;
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic signed [31:0] disp [3];
    } state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] mode = '0;
    logic [9:0] particle_index = '0;
    logic signed [31:0] vec_a_x = '0, vec_a_y = '0, vec_a_z = '0;
    logic signed [31:0] vec_b_x = '0, vec_b_y = '0, vec_b_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [9:0] out_index;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, disp_x, disp_y, disp_z;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    velocity_verlet_particle_update dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic signed [31:0] p_pos [3][1024];
    logic signed [31:0] p_vel [3][1024];
    logic signed [31:0] p_svel [3][1024];
    logic signed [31:0] p_sfrc [3][1024];
    logic signed [31:0] p_disp [3][1024];
    bit loaded [1024];
    bit stepped [1024];
    logic [15:0] dt_q;
    logic [30:0] blen_q [3];
    logic [31:0] binv_q [3];

    step_t pending_steps [$];
    state_t expected_states [$];
    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int cycles = 0;
    bit in_taken = 1'b0;

    function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -128'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic void advance_particle(step_t s);
        state_t r;
        logic signed [127:0] dt, f, v, u, d, q, k, sum;
        r.idx = s.idx;
        dt = $signed({112'd0, dt_q});
        for (int a = 0; a < 3; a++)
        begin
            f = s.a[a];
            v = p_vel[a][s.idx];
            if (s.mode == MODE_LOAD)
            begin
                p_pos[a][s.idx] = s.a[a];
                p_vel[a][s.idx] = s.b[a];
                p_disp[a][s.idx] = '0;
            end
            else if (s.mode == MODE_FIRST)
            begin
                u = v + ((dt * f) >>> 17);
                d = (u * dt) >>> 16;
                q = clamp32(p_pos[a][s.idx] + d);
                k = (q * $signed({96'd0, binv_q[a]})) >>> 48;
                p_sfrc[a][s.idx] = s.a[a];
                p_svel[a][s.idx] = v[31:0];
                p_disp[a][s.idx] = clamp32(p_disp[a][s.idx] + d);
                p_pos[a][s.idx] = clamp32(q - k * $signed({97'd0, blen_q[a]}));
                p_vel[a][s.idx] = clamp32(u);
            end
            else if (s.mode == MODE_SECND)
            begin
                sum = f + p_sfrc[a][s.idx];
                p_vel[a][s.idx] = clamp32(p_svel[a][s.idx] + ((dt * sum) >>> 17));
            end
            r.pos[a] = p_pos[a][s.idx];
            r.vel[a] = p_vel[a][s.idx];
            r.disp[a] = p_disp[a][s.idx];
        end
        expected_states.push_back(r);
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            out_stall <= ($urandom_range(99) < stall_pct);
            if (!in_valid || in_taken)
            begin
                if (pending_steps.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    step_t s;
                    s = pending_steps.pop_front();
                    in_valid <= 1'b1;
                    mode <= s.mode;
                    particle_index <= s.idx;
                    vec_a_x <= s.a[0]; vec_a_y <= s.a[1]; vec_a_z <= s.a[2];
                    vec_b_x <= s.b[0]; vec_b_y <= s.b[1]; vec_b_z <= s.b[2];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        step_t s;
        in_taken <= in_valid && !in_stall;
        if (in_valid && !in_stall)
        begin
            s.mode = mode;
            s.idx = particle_index;
            s.a[0] = vec_a_x; s.a[1] = vec_a_y; s.a[2] = vec_a_z;
            s.b[0] = vec_b_x; s.b[1] = vec_b_y; s.b[2] = vec_b_z;
            advance_particle(s);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        state_t e;
        logic signed [31:0] got [9];
        logic signed [31:0] want [9];
        bit bad;
        if (out_valid && !out_stall)
        begin
            if (expected_states.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction idx %0d", out_index);
            end
            else
            begin
                e = expected_states.pop_front();
                got = '{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, disp_x, disp_y, disp_z};
                for (int a = 0; a < 3; a++)
                begin
                    want[a] = e.pos[a];
                    want[3 + a] = e.vel[a];
                    want[6 + a] = e.disp[a];
                end
                bad = (out_index !== e.idx);
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want[i])
                        bad = 1;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch idx exp %0d got %0d exp %p got %p",
                                 e.idx, out_index, want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > 400000)
        begin
            $display("velocity_verlet_particle_update test failed");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t r, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (r)
            REG_TIME_STEP: dt_q = val[15:0];
            REG_BOX_X: blen_q[0] = val[30:0];
            REG_BOX_Y: blen_q[1] = val[30:0];
            REG_BOX_Z: blen_q[2] = val[30:0];
            REG_INV_X: binv_q[0] = val;
            REG_INV_Y: binv_q[1] = val;
            REG_INV_Z: binv_q[2] = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_steps.size() > 0 || in_valid || expected_states.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_box(logic [30:0] len);
        logic [31:0] inv;
        inv = (len == 0) ? 32'hFFFF_FFFF : 32'((64'd1 << 48) / len);
        for (int a = 0; a < 3; a++)
        begin
            write_reg(reg_idx_t'(REG_BOX_X + a), {1'b0, len});
            write_reg(reg_idx_t'(REG_INV_X + a), inv);
        end
    endtask

    function automatic logic signed [31:0] rand_val(int kind);
        case (kind)
            0: return $urandom();
            1: return $signed($urandom_range(20 << 16)) - (10 << 16);
            2: return 32'sh7FFF_FFFF;
            3: return 32'sh8000_0000;
            default: return $signed($urandom_range(2 << 16)) - (1 << 16);
        endcase
    endfunction

    function automatic void queue_step(logic [1:0] m, logic [9:0] i, int kind);
        step_t s;
        if (m != MODE_LOAD && !loaded[i])
            m = MODE_LOAD;
        if (m == MODE_SECND && !stepped[i])
            m = MODE_FIRST;
        s.mode = m;
        s.idx = i;
        for (int a = 0; a < 3; a++)
        begin
            s.a[a] = rand_val(kind);
            s.b[a] = rand_val(kind);
        end
        if (m == MODE_LOAD)
            loaded[i] = 1;
        if (m == MODE_FIRST)
            stepped[i] = 1;
        pending_steps.push_back(s);
    endfunction

    function automatic void queue_random(int n);
        for (int j = 0; j < n; j++)
            queue_step($urandom_range(3), $urandom_range(1023),
                       ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(1, 4));
    endfunction

    initial
    begin
        dt_q = 16'd655;
        for (int a = 0; a < 3; a++)
        begin
            blen_q[a] = 31'd655360;
            binv_q[a] = 32'd429496730;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every mode, no-op mode
        queue_step(MODE_LOAD, 10'd0, 2);
        queue_step(MODE_FIRST, 10'd0, 2);
        queue_step(MODE_SECND, 10'd0, 2);
        queue_step(MODE_LOAD, 10'd1023, 3);
        queue_step(MODE_FIRST, 10'd1023, 3);
        queue_step(MODE_SECND, 10'd1023, 3);
        queue_step(MODE_NOP, 10'd1023, 0);
        queue_step(MODE_LOAD, 10'd5, 1);
        queue_step(MODE_FIRST, 10'd5, 0);
        queue_step(MODE_FIRST, 10'd5, 1);
        queue_step(MODE_SECND, 10'd5, 1);
        queue_step(MODE_NOP, 10'd5, 1);
        drain();

        write_reg(REG_TIME_STEP, 32'hFFFF);
        set_box(31'h7FFF_FFFF);
        queue_random(150);
        drain();

        send_idle_pct = 45;
        write_reg(REG_TIME_STEP, 32'd0);
        set_box(31'd1);
        queue_random(150);
        drain();

        stall_pct = 45;
        send_idle_pct = 0;
        write_reg(REG_TIME_STEP, $urandom_range(65535));
        set_box(31'd655360);
        write_reg(REG_INV_Y, 32'hFFFF_FFFF);
        write_reg(REG_INV_Z, 32'd0);
        queue_random(150);
        drain();

        stall_pct = 28;
        send_idle_pct = 28;
        write_reg(REG_TIME_STEP, 32'd6554);
        set_box(31'($urandom_range(32'h7FFF_FFFF, 1)));
        queue_random(200);
        drain();

        stall_pct = 0;
        send_idle_pct = 0;
        write_reg(REG_TIME_STEP, 32'd655);
        set_box(31'd3 << 16);
        queue_random(150);
        drain();

        if (mismatches == 0)
            $display("velocity_verlet_particle_update test passed");
        else
            $display("velocity_verlet_particle_update test failed");
        $finish;
    end

endmodule
